FILE: rtl/assert_macros.svh
// Assertion macros used by the date adder design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("date adder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CDOA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("date adder assertion failed");

`endif

FILE: rtl/cdoa_pkg.sv
package cdoa_pkg;

  localparam int KindW   = 2;
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int OffW    = 21;
  localparam int StatusW = 2;

  // Internal years reach one past the largest configurable maximum year.
  localparam int IntYearW = 17;
  // Day serials from 1/1/1 for such years.
  localparam int DbyW = 26;
  localparam int SerW = DbyW + 1;
  // Month totals year * 12 + month plus offset, signed.
  localparam int AccW = 23;
  // Days within one year.
  localparam int RemW = 9;

  localparam int MaxYearDefault = 9999;

  // Reciprocal of 365.2425 scaled by 2^32, rounded up.
  localparam int unsigned EstRecip = 32'd11759222;
  localparam int EstShift = 32;

  typedef logic [IntYearW-1:0]     year_t;
  typedef logic [DbyW-1:0]         dby_t;
  typedef logic signed [SerW-1:0]  ser_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef enum logic [KindW-1:0] {
    KindDays   = 2'd0,
    KindMonths = 2'd1,
    KindYears  = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StLow     = 2'd1,
    StHigh    = 2'd2,
    StInvalid = 2'd3
  } status_e;

  // Quotient by 100 through a scaled reciprocal, exact for all internal years.
  function automatic year_t div100(year_t x);
    logic [IntYearW+18-1:0] p;
    p = (IntYearW+18)'(x) * (IntYearW+18)'(18'd167773);
    return year_t'(p >> 24);
  endfunction

  function automatic logic is_leap(year_t y);
    year_t q;
    logic  cent;
    q    = div100(y);
    cent = (y == year_t'(q * 7'd100));
    return (y != '0) && (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_days(logic [MonthW-1:0] m, logic lp);
    logic [DayW-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = lp ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [RemW-1:0] days_before_month(logic [MonthW-1:0] m, logic lp);
    logic [RemW-1:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    if (lp && (m > 4'd2)) begin
      r = r + 9'd1;
    end
    return r;
  endfunction

  // Days from 1/1/1 up to 1/1 of year y, for y of at least one.
  function automatic dby_t days_before_year(year_t y);
    year_t p;
    year_t q;
    p = y - year_t'(1);
    q = div100(p);
    return dby_t'(p) * dby_t'(365) + dby_t'(p >> 2) - dby_t'(q) + dby_t'(q >> 2);
  endfunction

endpackage

FILE: rtl/cdoa_if.sv
interface cdoa_req_if import cdoa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic [YearW-1:0]         start_year;
  logic [MonthW-1:0]        start_month;
  logic [DayW-1:0]          start_day;
  logic signed [OffW-1:0]   offset;

  modport source (output valid, kind, start_year, start_month, start_day, offset,
                  input ready);
  modport sink   (input valid, kind, start_year, start_month, start_day, offset,
                  output ready);
endinterface

interface cdoa_rsp_if import cdoa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YearW-1:0]    new_year;
  logic [MonthW-1:0]   new_month;
  logic [DayW-1:0]     new_day;
  logic [StatusW-1:0]  status;

  modport source (output valid, new_year, new_month, new_day, status, input ready);
  modport sink   (input valid, new_year, new_month, new_day, status, output ready);
endinterface

FILE: rtl/calendar_date_offset_adder.sv
// Channel   Direction  Contents
// req_i     in         kind, start_year, start_month, start_day, offset
// rsp_o     out        new_year, new_month, new_day, status
//
// Each request passes five register stages, and one request can enter every cycle
// while the output register is free or being emptied.
// The stage count is set by the day path: serial forming, year estimate,
// year correction against three candidate year starts, then the month search.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
// A stalled result freezes the whole pipe, so nothing is lost or repeated.
// Empty stages do not fill while the result waits; bubbles stay in place.

`include "assert_macros.svh"

module calendar_date_offset_adder import cdoa_pkg::*; #(
  parameter int unsigned MaxYear = MaxYearDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdoa_req_if.sink   req_i,
  cdoa_rsp_if.source rsp_o
);

  localparam year_t MaxYearC = year_t'(MaxYear);
  localparam acc_t  AccMax   = acc_t'(MaxYear);
  // Serial of 12/31 of the maximum year.
  localparam dby_t  TopSer   = dby_t'(365 * MaxYear + MaxYear / 4 - MaxYear / 100
                                      + MaxYear / 400 - 1);

  // The pipe advances whenever the output register is free or being emptied.
  logic en;
  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  // Stage 1: captured request.
  logic                    v1_q;
  logic [KindW-1:0]        k1_q;
  logic [YearW-1:0]        y1_q;
  logic [MonthW-1:0]       m1_q;
  logic [DayW-1:0]         d1_q;
  logic signed [OffW-1:0]  off1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q   <= req_i.kind;
      y1_q   <= req_i.start_year;
      m1_q   <= req_i.start_month;
      d1_q   <= req_i.start_day;
      off1_q <= req_i.offset;
    end
  end

  // Validate the date and form the day serial plus offset, or the month or
  // year total plus offset.
  year_t           y1e;
  logic            lp1;
  logic [DayW-1:0] ml1;
  logic            bad1;
  ser_t            ser1_d;
  acc_t            acc1_d;

  always_comb begin
    y1e  = year_t'(y1_q);
    lp1  = is_leap(y1e);
    ml1  = month_days(m1_q, lp1);
    bad1 = (y1_q == '0) || (y1e > MaxYearC) || (m1_q == '0) || (m1_q > 4'd12)
           || (d1_q == '0) || (d1_q > ml1);
    ser1_d = ser_t'(days_before_year(y1e)) + ser_t'(days_before_month(m1_q, lp1))
             + ser_t'(d1_q) - ser_t'(1) + ser_t'(off1_q);
    if (k1_q == KindMonths) begin
      acc1_d = acc_t'({y1_q, 3'b000}) + acc_t'({y1_q, 2'b00}) + acc_t'(m1_q)
               - acc_t'(1) + acc_t'(off1_q);
    end else if (k1_q == KindYears) begin
      acc1_d = acc_t'(y1_q) + acc_t'(off1_q);
    end else begin
      // Day shifts take the year from the serial; the unused kind keeps it.
      acc1_d = acc_t'(y1_q);
    end
  end

  // Stage 2.
  logic              v2_q;
  logic [KindW-1:0]  k2_q;
  status_e           st2_q;
  ser_t              ser2_q;
  acc_t              acc2_q;
  logic [MonthW-1:0] m2_q;
  logic [DayW-1:0]   d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k2_q   <= k1_q;
      st2_q  <= bad1 ? StInvalid : StOk;
      ser2_q <= ser1_d;
      acc2_q <= acc1_d;
      m2_q   <= m1_q;
      d2_q   <= d1_q;
    end
  end

  // Range checks, a year estimate from the serial and the month quotient.
  logic [DbyW+32-1:0]  est_prod;
  year_t               est2;
  logic [39:0]         q_prod;
  year_t               q2;
  status_e             st2_d;

  always_comb begin
    est_prod = (DbyW+32)'(ser2_q[DbyW-1:0]) * (DbyW+32)'(EstRecip);
    est2     = year_t'(est_prod >> EstShift) + year_t'(1);
    // Quotient by 12 as a quarter followed by a third.
    q_prod   = 40'(acc2_q[20:2]) * 40'(20'hAAAAB);
    q2       = year_t'(q_prod >> 21);
    st2_d    = st2_q;
    if (st2_q != StInvalid) begin
      unique case (k2_q)
        KindDays: begin
          if (ser2_q < 0) begin
            st2_d = StLow;
          end else if (ser2_q > ser_t'(TopSer)) begin
            st2_d = StHigh;
          end
        end
        KindMonths: begin
          if (acc2_q < acc_t'(12)) begin
            st2_d = StLow;
          end else if (q2 > MaxYearC) begin
            st2_d = StHigh;
          end
        end
        KindYears: begin
          if (acc2_q < acc_t'(1)) begin
            st2_d = StLow;
          end else if (acc2_q > AccMax) begin
            st2_d = StHigh;
          end
        end
        default: st2_d = st2_q;
      endcase
    end
  end

  // Stage 3.
  logic              v3_q;
  logic [KindW-1:0]  k3_q;
  status_e           st3_q;
  dby_t              ser3_q;
  year_t             est3_q;
  acc_t              acc3_q;
  year_t             q3_q;
  logic [MonthW-1:0] m3_q;
  logic [DayW-1:0]   d3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k3_q   <= k2_q;
      st3_q  <= st2_d;
      ser3_q <= ser2_q[DbyW-1:0];
      est3_q <= est2;
      acc3_q <= acc2_q;
      q3_q   <= q2;
      m3_q   <= m2_q;
      d3_q   <= d2_q;
    end
  end

  // The estimate is within one year of the truth, so the year is settled by
  // comparing against the starts of three neighboring years. Month and year
  // shifts get their month and clamp the day here.
  year_t             cand;
  dby_t              b0;
  dby_t              b1;
  dby_t              b2;
  dby_t              base;
  dby_t              rem_full;
  year_t             ny3;
  logic [MonthW-1:0] nm3;
  logic [DayW-1:0]   ml3;
  logic [DayW-1:0]   nd3;
  year_t             y3_d;
  logic [RemW-1:0]   r3_d;
  acc_t              nm_full;

  always_comb begin
    cand = (est3_q <= year_t'(1)) ? year_t'(1) : est3_q - year_t'(1);
    b0   = days_before_year(cand);
    b1   = days_before_year(cand + year_t'(1));
    b2   = days_before_year(cand + year_t'(2));
    if (ser3_q >= b2) begin
      y3_d = cand + year_t'(2);
      base = b2;
    end else if (ser3_q >= b1) begin
      y3_d = cand + year_t'(1);
      base = b1;
    end else begin
      y3_d = cand;
      base = b0;
    end
    rem_full = ser3_q - base;
    r3_d     = rem_full[RemW-1:0];

    nm_full = acc3_q - acc_t'({q3_q, 3'b000}) - acc_t'({q3_q, 2'b00}) + acc_t'(1);
    if (k3_q == KindMonths) begin
      ny3 = q3_q;
      nm3 = nm_full[MonthW-1:0];
    end else if (k3_q == KindYears) begin
      ny3 = acc3_q[IntYearW-1:0];
      nm3 = m3_q;
    end else begin
      ny3 = year_t'(acc3_q[YearW-1:0]);
      nm3 = m3_q;
    end
    ml3 = month_days(nm3, is_leap(ny3));
    nd3 = (d3_q > ml3) ? ml3 : d3_q;
    if (k3_q != KindDays) begin
      y3_d = ny3;
    end
  end

  // Stage 4.
  logic              v4_q;
  logic [KindW-1:0]  k4_q;
  status_e           st4_q;
  year_t             y4_q;
  logic [RemW-1:0]   r4_q;
  logic [MonthW-1:0] m4_q;
  logic [DayW-1:0]   d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k4_q  <= k3_q;
      st4_q <= st3_q;
      y4_q  <= y3_d;
      r4_q  <= r3_d;
      m4_q  <= nm3;
      d4_q  <= nd3;
    end
  end

  // Month search within the year for day shifts, then the special results.
  logic              lp4;
  logic [MonthW-1:0] mm4;
  logic [RemW-1:0]   dd_full;
  logic [YearW-1:0]  yo_d;
  logic [MonthW-1:0] mo_d;
  logic [DayW-1:0]   do_d;

  always_comb begin
    lp4 = is_leap(y4_q);
    mm4 = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (r4_q >= days_before_month(MonthW'(i), lp4)) begin
        mm4 = MonthW'(i);
      end
    end
    dd_full = r4_q - days_before_month(mm4, lp4) + RemW'(1);

    if (k4_q == KindDays) begin
      yo_d = y4_q[YearW-1:0];
      mo_d = mm4;
      do_d = dd_full[DayW-1:0];
    end else begin
      yo_d = y4_q[YearW-1:0];
      mo_d = m4_q;
      do_d = d4_q;
    end

    unique case (st4_q)
      StInvalid: begin
        yo_d = '0;
        mo_d = '0;
        do_d = '0;
      end
      StLow: begin
        yo_d = YearW'(1);
        mo_d = MonthW'(1);
        do_d = DayW'(1);
      end
      StHigh: begin
        yo_d = MaxYearC[YearW-1:0];
        mo_d = MonthW'(12);
        do_d = DayW'(31);
      end
      default: ;
    endcase
  end

  // Output register.
  logic               vo_q;
  logic [YearW-1:0]   yo_q;
  logic [MonthW-1:0]  mo_q;
  logic [DayW-1:0]    do_q;
  status_e            so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yo_q <= yo_d;
      mo_q <= mo_d;
      do_q <= do_d;
      so_q <= st4_q;
    end
  end

  assign rsp_o.valid     = vo_q;
  assign rsp_o.new_year  = yo_q;
  assign rsp_o.new_month = mo_q;
  assign rsp_o.new_day   = do_q;
  assign rsp_o.status    = so_q;

  logic [4:0] vld_all;
  assign vld_all = {v1_q, v2_q, v3_q, v4_q, vo_q};

  // A frozen pipe keeps every stage's occupancy.
  `CDOA_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !en, $stable(vld_all))
  // An invalid start date gives an all-zero date.
  `CDOA_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, vo_q && (so_q == StInvalid), (yo_q == '0) && (mo_q == '0) && (do_q == '0))
  // Every other result is a real calendar position.
  `CDOA_ASSERT_IMP(a_date_range, clk_i, rst_ni, vo_q && (so_q != StInvalid), (mo_q >= 4'd1) && (mo_q <= 4'd12) && (do_q >= 5'd1))

endmodule
